/* rtl/core/ahdip_pkg.sv */
// ----------------------------------------------------------------------------
// ahdip_pkg
// shared types and constants of the ascii hex/decimal integer parser
// ----------------------------------------------------------------------------
package ahdip_pkg;

    localparam int CHAR_W  = 8;
    localparam int VALUE_W = 32;
    localparam int STOP_W  = 9;
    localparam int NIB_W   = 4;

    // apb register map
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_RADIX_MODE = 1'b0;

    // radix mode codes
    localparam logic RADIX_DEC = 1'b0;
    localparam logic RADIX_HEX = 1'b1;

    // character codes
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;

    // offsets from character code to digit value
    localparam logic [CHAR_W-1:0] OFS_DIGIT = 8'h30;
    localparam logic [CHAR_W-1:0] OFS_UPPER = 8'h37;
    localparam logic [CHAR_W-1:0] OFS_LOWER = 8'h57;

    typedef struct packed {
        logic               found;
        logic [VALUE_W-1:0] value;
        logic [STOP_W-1:0]  stop_index;
    } t_result;

endpackage

/* rtl/core/ahdip_stream_if.sv */
// ----------------------------------------------------------------------------
// ahdip stream interfaces
// valid/ready channels for input characters and parse results
// ----------------------------------------------------------------------------
interface ahdip_char_if import ahdip_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_byte;
    logic              last_byte;

    modport source (output valid, output char_byte, output last_byte, input ready);
    modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

interface ahdip_result_if import ahdip_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               found;
    logic [VALUE_W-1:0] value;
    logic [STOP_W-1:0]  stop_index;

    modport source (output valid, output found, output value, output stop_index,
                    input ready);
    modport sink   (input valid, input found, input value, input stop_index,
                    output ready);
endinterface

/* rtl/core/ahdip_apb_regs.sv */
// ----------------------------------------------------------------------------
// ahdip_apb_regs
// apb register file holding the radix mode
// ----------------------------------------------------------------------------
module ahdip_apb_regs import ahdip_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  o_radix_mode
);

    logic r_radix_mode;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_RADIX_MODE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix_mode <= RADIX_DEC;
        end else if (wr_en) begin
            r_radix_mode <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_RADIX_MODE) begin
            prdata[0] = r_radix_mode;
        end
    end

    assign o_radix_mode = r_radix_mode;

endmodule

/* rtl/core/ahdip_parse.sv */
// ----------------------------------------------------------------------------
// ahdip_parse
// parse state and one-character update step
// ----------------------------------------------------------------------------
module ahdip_parse import ahdip_pkg::*; #(
    parameter int MAX_LEN = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [CHAR_W-1:0] i_char,
    input  logic              i_last,
    input  logic              i_radix_mode,
    output logic              o_emit,
    output t_result           o_result
);

    localparam int POS_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [VALUE_W-1:0] r_acc,    n_acc;
    logic               r_digit,  n_digit;
    logic               r_neg,    n_neg;
    logic [POS_W-1:0]   r_pos;
    logic               r_finished;

    logic               accepted;
    logic               buf_end;
    logic               is_dec, is_upper, is_lower, is_x;
    logic [CHAR_W-1:0]  diff;
    logic [NIB_W-1:0]   nib;
    logic [VALUE_W-1:0] times_ten;
    logic [VALUE_W-1:0] magnitude;
    logic [POS_W:0]     pos_plus;

    assign is_dec   = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_upper = (i_char >= CH_UPPER_A) && (i_char <= CH_UPPER_F);
    assign is_lower = (i_char >= CH_LOWER_A) && (i_char <= CH_LOWER_F);
    assign is_x     = (i_char == CH_UPPER_X) || (i_char == CH_LOWER_X);

    always_comb begin
        priority if (is_upper) begin
            diff = i_char - OFS_UPPER;
        end else if (is_lower) begin
            diff = i_char - OFS_LOWER;
        end else begin
            diff = i_char - OFS_DIGIT;
        end
    end
    assign nib = diff[NIB_W-1:0];

    // acc * 10 as two shifted terms, plus the digit value
    assign times_ten = (r_acc << 3) + (r_acc << 1) + VALUE_W'(nib);

    always_comb begin
        n_acc    = r_acc;
        n_digit  = r_digit;
        n_neg    = r_neg;
        accepted = 1'b1;
        if (i_radix_mode == RADIX_HEX) begin
            priority if (is_dec || is_upper || is_lower) begin
                n_acc   = {r_acc[VALUE_W-NIB_W-1:0], nib};
                n_digit = 1'b1;
            end else if (is_x) begin
                n_acc   = '0;
                n_digit = 1'b0;
            end else begin
                accepted = 1'b0;
            end
        end else begin
            priority if ((i_char == CH_MINUS) && !r_digit) begin
                n_neg = 1'b1;
            end else if (is_dec) begin
                n_acc   = times_ten;
                n_digit = 1'b1;
            end else begin
                accepted = 1'b0;
            end
        end
    end

    assign buf_end  = i_last || (r_pos >= POS_W'(MAX_LEN - 1));
    assign pos_plus = {1'b0, r_pos} + (POS_W + 1)'(1);
    assign o_emit   = i_step && !r_finished && (!accepted || buf_end);

    assign magnitude = n_neg ? (VALUE_W'(0) - n_acc) : n_acc;

    always_comb begin
        o_result.found      = n_digit;
        o_result.value      = n_digit ? magnitude : '0;
        o_result.stop_index = accepted ? STOP_W'(pos_plus) : STOP_W'(r_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_digit    <= 1'b0;
            r_neg      <= 1'b0;
            r_pos      <= '0;
            r_finished <= 1'b0;
        end else if (i_step) begin
            if (buf_end) begin
                r_acc      <= '0;
                r_digit    <= 1'b0;
                r_neg      <= 1'b0;
                r_pos      <= '0;
                r_finished <= 1'b0;
            end else begin
                r_pos <= pos_plus[POS_W-1:0];
                if (!r_finished) begin
                    r_acc      <= n_acc;
                    r_digit    <= n_digit;
                    r_neg      <= n_neg;
                    r_finished <= !accepted;
                end
            end
        end
    end

endmodule

/* rtl/core/ascii_hex_dec_integer_parser_unit.sv */
// ----------------------------------------------------------------------------
// ascii_hex_dec_integer_parser_unit
// parses a leading hex or decimal integer from a byte stream
// ----------------------------------------------------------------------------
// a result passes the input register and then the result register before it appears on o_res
// throughput: one byte per cycle while o_res.ready is high; the parse state
//   update (shift-add by ten, or a nibble shift in hex mode) is combinational
// a full output register with ready low stalls the input register behind it
// reset: synchronous active-low i_rst_n clears the parse state, radix mode to decimal
// ----------------------------------------------------------------------------
module ascii_hex_dec_integer_parser_unit import ahdip_pkg::*; #(
    parameter int MAX_LEN = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ahdip_char_if.sink            i_in,
    ahdip_result_if.source        o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // input register
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;

    // result register
    logic              r_out_valid;
    t_result           r_out;

    logic              radix_mode;
    logic              step_fire;
    logic              emit;
    t_result           result;

    // configuration registers
    ahdip_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_radix_mode (radix_mode)
    );

    // the held byte advances when the result slot is free or being drained
    assign step_fire  = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || step_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_char <= i_in.char_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    // parse state and per-character update
    ahdip_parse #(
        .MAX_LEN (MAX_LEN)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step_fire),
        .i_char       (r_in_char),
        .i_last       (r_in_last),
        .i_radix_mode (radix_mode),
        .o_emit       (emit),
        .o_result     (result)
    );

    // result slot: loaded on a step that emits, freed when the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire) begin
            r_out_valid <= emit;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire && emit) begin
            r_out <= result;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.found      = r_out.found;
    assign o_res.value      = r_out.value;
    assign o_res.stop_index = r_out.stop_index;

endmodule
